[rtl/core/rlz_pkg.sv]
// Shared types and constants for the RefPack LZ decompressor.
// No dependencies; imported by every module of the block except rlz_ram.
`timescale 1ns / 1ps
package rlz_pkg;
	localparam int HIST_AW = 17;                 // history address bits
	localparam int WINDOW_BYTES = 1 << HIST_AW;  // history depth
	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] OP_BYTE    = 2'd0;
	localparam logic [1:0] OP_DRAIN   = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BUSY_COPY = 3'd1;
	localparam logic [2:0] ST_SIZE_ERR  = 3'd2;
	localparam logic [2:0] ST_AFTER_END = 3'd3;
	localparam logic [2:0] ST_BAD_REF   = 3'd4;

	typedef enum logic [1:0] {K_NONE, K_LIT, K_COPY} kind_t;

	// One classified request from the parser to the history side
	typedef struct packed {
		kind_t               kind;
		logic [7:0]          lit;
		logic [HIST_AW-1:0]  raddr;
		logic [HIST_AW-1:0]  waddr;
		logic                pend;
		logic                fin;
		logic [2:0]          status;
	} req_t;
endpackage

[rtl/core/rlz_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rlz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/core/rlz_front.sv]
// Stream parser: header, command decode and copy bookkeeping, one item a cycle while in_ready is high.
// Depends on rlz_pkg; feeds classified requests into rlz_fifo.
`timescale 1ns / 1ps
module rlz_front import rlz_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [23:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	output req_t        req
);
	typedef enum logic [3:0] {
		PH_HDR_FLAG, PH_HDR_OPT, PH_HDR_SKIP, PH_HDR_SIZE, PH_CMD,
		PH_OPERANDS, PH_LITERALS, PH_COPY, PH_DONE, PH_FAILED
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [7:0]         cmd_q, cmd_n;
	logic [23:0]        opnd_q, opnd_n;
	logic [2:0]         bexp_q, bexp_n;
	logic [6:0]         lit_q, lit_n;
	logic [17:0]        dist_q, dist_n;
	logic [10:0]        mleft_q, mleft_n;
	logic [23:0]        wcnt_q, wcnt_n;
	logic [23:0]        dsize_q, dsize_n;
	logic               end_q, end_n;
	logic [HIST_AW-1:0] wptr_q, wptr_n;
	logic [23:0]        explen_q;

	logic               acc;
	assign acc = in_valid && in_ready;

	always_comb begin
		logic       put;
		logic [1:0] nlit;
		logic [6:0] n;
		logic       chk;
		phase_n = phase_q; cmd_n = cmd_q; opnd_n = opnd_q; bexp_n = bexp_q;
		lit_n = lit_q; dist_n = dist_q; mleft_n = mleft_q; dsize_n = dsize_q;
		end_n = end_q; wptr_n = wptr_q;
		wcnt_n = wcnt_q;
		put = 1'b0; nlit = 2'd0; n = 7'd0; chk = 1'b0;
		req.kind = K_NONE;
		req.lit = 8'd0;
		req.raddr = wptr_q - HIST_AW'(dist_q);
		req.waddr = wptr_q;
		req.status = ST_OK;

		case (opcode)
			OP_RESTART: begin
				phase_n = PH_HDR_FLAG; cmd_n = '0; opnd_n = '0; bexp_n = '0;
				lit_n = '0; dist_n = '0; mleft_n = '0; wcnt_n = '0;
				dsize_n = '0; end_n = 1'b0;
			end
			OP_DRAIN: begin
				if (phase_q == PH_COPY && mleft_q != 11'd0) begin
					req.kind = K_COPY;
					put = 1'b1;
					mleft_n = mleft_q - 11'd1;
					if (mleft_n == 11'd0) phase_n = PH_CMD;
				end
			end
			OP_BYTE: begin
				case (phase_q)
					PH_HDR_FLAG: begin
						if (data_byte[0]) begin
							bexp_n = 3'd3; phase_n = PH_HDR_OPT;
						end else phase_n = PH_HDR_SKIP;
					end
					PH_HDR_OPT: begin
						bexp_n = bexp_q - 3'd1;
						if (bexp_n == 3'd0) phase_n = PH_HDR_SKIP;
					end
					PH_HDR_SKIP: begin
						bexp_n = 3'd3; dsize_n = '0; phase_n = PH_HDR_SIZE;
					end
					PH_HDR_SIZE: begin
						dsize_n = {dsize_q[15:0], data_byte};
						bexp_n = bexp_q - 3'd1;
						if (bexp_n == 3'd0) begin
							if (dsize_n != explen_q) begin
								phase_n = PH_FAILED; req.status = ST_SIZE_ERR;
							end else phase_n = PH_CMD;
						end
					end
					PH_CMD: begin
						cmd_n = data_byte;
						opnd_n = '0;
						if (data_byte < 8'hE0) begin
							bexp_n = (data_byte < 8'h80) ? 3'd1 :
							         (data_byte < 8'hC0) ? 3'd2 : 3'd3;
							phase_n = PH_OPERANDS;
						end else begin
							n = {data_byte[4:0], 2'b00} + 7'd4;
							// end command: 0..3 final literals
							if (data_byte >= 8'hFC) begin
								end_n = 1'b1; n = {5'd0, data_byte[1:0]};
							end
							lit_n = n;
							phase_n = (n != 7'd0) ? PH_LITERALS :
							          (end_n ? PH_DONE : PH_CMD);
						end
					end
					PH_OPERANDS: begin
						opnd_n = {opnd_q[15:0], data_byte};
						bexp_n = bexp_q - 3'd1;
						if (bexp_n == 3'd0) begin
							if (cmd_q < 8'h80) begin
								nlit = cmd_q[1:0];
								dist_n = {8'd0, cmd_q[6:5], opnd_n[7:0]} + 18'd1;
								mleft_n = {8'd0, cmd_q[4:2]} + 11'd3;
							end else if (cmd_q < 8'hC0) begin
								nlit = opnd_n[15:14];
								dist_n = {4'd0, opnd_n[13:8], opnd_n[7:0]} + 18'd1;
								mleft_n = {5'd0, cmd_q[5:0]} + 11'd4;
							end else begin
								nlit = cmd_q[1:0];
								dist_n = {1'b0, cmd_q[4], opnd_n[23:8]} + 18'd1;
								mleft_n = {3'd0, opnd_n[7:0]} + {1'b0, cmd_q[3:2], 8'd0}
								          + 11'd5;
							end
							if (nlit != 2'd0) begin
								lit_n = {5'd0, nlit}; phase_n = PH_LITERALS;
							end else chk = 1'b1;
						end
					end
					PH_LITERALS: begin
						req.kind = K_LIT;
						req.lit = data_byte;
						put = 1'b1;
						lit_n = lit_q - 7'd1;
						if (lit_n == 7'd0) begin
							if (end_q) phase_n = PH_DONE;
							else if (cmd_q < 8'hE0) chk = 1'b1;
							else phase_n = PH_CMD;
						end
					end
					PH_COPY:  req.status = ST_BUSY_COPY;
					PH_DONE:  req.status = ST_AFTER_END;
					default:  req.status = ST_SIZE_ERR;
				endcase
			end
			default: ;
		endcase

		// every emitted byte goes to history
		if (put) begin
			wptr_n = wptr_q + HIST_AW'(1);
			if (wcnt_q != 24'hFFFFFF) wcnt_n = wcnt_q + 24'd1;
		end
		// start of back-reference: reject distances beyond bytes written
		if (chk) begin
			if ({6'd0, dist_n} > wcnt_n || dist_n == 18'd0) begin
				mleft_n = '0; phase_n = PH_CMD; req.status = ST_BAD_REF;
			end else phase_n = PH_COPY;
		end
		req.pend = (phase_n == PH_COPY) && (mleft_n != 11'd0);
		req.fin = (phase_n == PH_DONE);
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR_FLAG; cmd_q <= '0; opnd_q <= '0; bexp_q <= '0;
			lit_q <= '0; dist_q <= '0; mleft_q <= '0; wcnt_q <= '0;
			dsize_q <= '0; end_q <= 1'b0; wptr_q <= '0; explen_q <= '0;
		end else begin
			if (cfg_wen) explen_q <= cfg_wdata;
			if (acc) begin
				phase_q <= phase_n; cmd_q <= cmd_n; opnd_q <= opnd_n;
				bexp_q <= bexp_n; lit_q <= lit_n; dist_q <= dist_n;
				mleft_q <= mleft_n; wcnt_q <= wcnt_n; dsize_q <= dsize_n;
				end_q <= end_n; wptr_q <= wptr_n;
			end
		end
	end

	a_copy_has_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_COPY |-> mleft_q != 11'd0) else $error("copy with no length");
	a_copy_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_COPY |-> {6'd0, dist_q} <= wcnt_q)
		else $error("copy reaches before stream start");
endmodule

[rtl/core/rlz_fifo.sv]
// Short request queue between parser and history side.
// Depends on rlz_pkg (req_t, QUEUE_DEPTH).
`timescale 1ns / 1ps
module rlz_fifo import rlz_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_req,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output req_t head
);
	localparam int PW = $clog2(QUEUE_DEPTH);

	req_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign full = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_req;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PW'(1);
			if (pop) rd_q <= rd_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule

[rtl/core/rlz_back.sv]
// History side: reads and writes the history RAM and registers the result.
// Depends on rlz_pkg and rlz_ram; pops requests from rlz_fifo.
`timescale 1ns / 1ps
module rlz_back import rlz_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_nonempty,
	input  req_t        q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_data
);
	req_t       s1_req;
	logic       s1_valid, s1_fwd;
	logic [7:0] s1_fwdb;
	logic [7:0] rd_data, byte_s1;
	logic       adv, re, we;

	assign adv = !out_valid || out_ready;
	assign q_pop = adv && q_nonempty;
	assign re = q_pop && (q_head.kind == K_COPY);
	assign we = adv && s1_valid && (s1_req.kind != K_NONE);

	rlz_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
		.clk(clk), .we(we), .waddr(s1_req.waddr), .wdata(byte_s1),
		.re(re), .raddr(q_head.raddr), .rdata(rd_data)
	);

	// byte of the request in stage 1; bypass the byte that was being written when it was read
	always_comb begin
		case (s1_req.kind)
			K_LIT:   byte_s1 = s1_req.lit;
			K_COPY:  byte_s1 = s1_fwd ? s1_fwdb : rd_data;
			default: byte_s1 = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0; s1_fwd <= 1'b0; out_valid <= 1'b0;
		end else if (adv) begin
			s1_valid <= q_pop;
			s1_fwd <= re && we && (s1_req.waddr == q_head.raddr);
			out_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_req <= q_head;
			s1_fwdb <= byte_s1;
			out_data <= {2'b00, s1_req.status, s1_req.fin, s1_req.pend, byte_s1,
			             s1_req.kind != K_NONE};
		end
	end

	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		re && we && s1_req.waddr == q_head.raddr |=> s1_fwd)
		else $error("read of byte in flight not bypassed");
	a_pop_safe: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> adv) else $error("pop while stalled");
endmodule

[rtl/core/refpack_lz_decompressor.sv]
// Top level of the RefPack LZ decompressor: parser, request queue, history side.
// Depends on rlz_pkg, rlz_front, rlz_fifo, rlz_back.
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: opcode[1:0], data_byte[9:2]
// m_*       out  m_tvalid/m_tready  m_tdata: byte_valid, out_byte, copy_pending,
//                                            finished, status
// cfg_*     in   cfg_wen            cfg_wdata: expected_length
//
// One item per cycle sustained while the queue is not full; a result passes the request
// queue, stage 1 and the output register to m_*. The parser decodes every item combinationally;
// the history RAM is read and written at most once each per item, with the read registered.
// Reset clears all control state; history is not cleared.
// Input stalls only when the four-entry queue fills behind a stalled output.
`timescale 1ns / 1ps
module refpack_lz_decompressor import rlz_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // opcode[1:0], data_byte[9:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // byte_valid[0], out_byte[8:1], copy_pending[9],
	                               // finished[10], status[13:11]
	input  logic        cfg_wen,
	input  logic [23:0] cfg_wdata
);
	req_t req, head;
	logic full, nonempty, pop;

	assign s_tready = !full;

	rlz_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.opcode(s_tdata[1:0]), .data_byte(s_tdata[9:2]), .req(req)
	);

	rlz_fifo u_queue (
		.clk(clk), .arst_n(arst_n), .push(s_tvalid && s_tready), .push_req(req),
		.full(full), .pop(pop), .nonempty(nonempty), .head(head)
	);

	rlz_back u_back (
		.clk(clk), .arst_n(arst_n), .q_nonempty(nonempty), .q_head(head),
		.q_pop(pop), .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
	);
endmodule

[verif/tb_refpack_lz_decompressor.sv]
// Self-checking testbench for refpack_lz_decompressor: drives header, command and drain
// requests, predicts each result in a scoreboard and compares every field. Depends on rlz_pkg.
`timescale 1ns / 1ps
module tb_refpack_lz_decompressor import rlz_pkg::*; ();

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 600000;

	typedef enum logic [3:0] {
		P_FLAG, P_OPT, P_SKIP, P_SIZE, P_CMD, P_OPER, P_LIT, P_COPY, P_DONE, P_FAIL
	} parse_t;

	typedef struct {
		bit       v;
		bit [7:0] ob;
		bit       pend;
		bit       fin;
		bit [2:0] st;
	} lz_result_t;

	// Decoder model plus queue of expected results
	class lz_scoreboard;
		bit [7:0]           hist [WINDOW_BYTES];
		bit [HIST_AW-1:0]   wptr;
		bit [23:0]          exp_len, written, decl, opnd;
		bit [7:0]           cmd;
		parse_t             phase;
		int                 need, lits, mdist, mleft;
		bit                 ended;
		lz_result_t         expq[$];
		int                 nchecked, nerrors;

		function void clear();
			phase = P_FLAG;
			cmd = 0; opnd = 0; need = 0; lits = 0; mdist = 0; mleft = 0;
			written = 0; decl = 0; ended = 0;
		endfunction

		function void init();
			wptr = 0; exp_len = 0; nchecked = 0; nerrors = 0;
			clear();
		endfunction

		function void put(bit [7:0] b);
			hist[wptr] = b;
			wptr++;
			if (written != 24'hFFFFFF) written++;
		endfunction

		function bit [2:0] start_copy();
			if (mdist > int'(written) || mdist == 0) begin
				mleft = 0;
				phase = P_CMD;
				return ST_BAD_REF;
			end
			phase = P_COPY;
			return ST_OK;
		endfunction

		// All operand bytes of a copy command are in
		function bit [2:0] decode();
			int c, o, b1, b2, b3, lit;
			c = int'(cmd); o = int'(opnd);
			if (c < 'h80) begin
				lit = c & 3;
				mdist = ((c & 'h60) << 3) + (o & 'hFF) + 1;
				mleft = ((c >> 2) & 7) + 3;
			end else if (c < 'hC0) begin
				b1 = (o >> 8) & 'hFF;
				lit = b1 >> 6;
				mdist = ((b1 & 'h3F) << 8) + (o & 'hFF) + 1;
				mleft = (c & 'h3F) + 4;
			end else begin
				b1 = (o >> 16) & 'hFF; b2 = (o >> 8) & 'hFF; b3 = o & 'hFF;
				lit = c & 3;
				mdist = ((c & 'h10) << 12) + (b1 << 8) + b2 + 1;
				mleft = b3 + ((c & 'h0C) << 6) + 5;
			end
			if (lit != 0) begin
				lits = lit;
				phase = P_LIT;
				return ST_OK;
			end
			return start_copy();
		endfunction

		// Accepted request: advance the model and queue its result
		function void note(logic [1:0] op, logic [7:0] b);
			lz_result_t r;
			bit [HIST_AW-1:0] rd;
			int n;
			r = '{default: 0};
			if (op == OP_RESTART) begin
				clear();
			end else if (op == OP_DRAIN) begin
				if (phase == P_COPY && mleft != 0) begin
					rd = wptr - mdist[HIST_AW-1:0];
					r.ob = hist[rd];
					r.v = 1;
					put(r.ob);
					mleft--;
					if (mleft == 0) phase = P_CMD;
				end
			end else if (op == OP_BYTE) begin
				case (phase)
					P_FLAG: begin
						if (b[0]) begin
							need = 3;
							phase = P_OPT;
						end else phase = P_SKIP;
					end
					P_OPT: begin
						need--;
						if (need == 0) phase = P_SKIP;
					end
					P_SKIP: begin
						need = 3;
						decl = 0;
						phase = P_SIZE;
					end
					P_SIZE: begin
						decl = {decl[15:0], b};
						need--;
						if (need == 0) begin
							if (decl != exp_len) begin
								phase = P_FAIL;
								r.st = ST_SIZE_ERR;
							end else phase = P_CMD;
						end
					end
					P_CMD: begin
						cmd = b;
						opnd = 0;
						if (b < 8'hE0) begin
							need = (b < 8'h80) ? 1 : (b < 8'hC0) ? 2 : 3;
							phase = P_OPER;
						end else begin
							n = int'(b[4:0]) * 4 + 4;
							if (n > 'h70) begin
								ended = 1;
								n = int'(b[1:0]);
							end
							lits = n;
							phase = (n != 0) ? P_LIT : (ended ? P_DONE : P_CMD);
						end
					end
					P_OPER: begin
						opnd = {opnd[15:0], b};
						need--;
						if (need == 0) r.st = decode();
					end
					P_LIT: begin
						r.ob = b;
						r.v = 1;
						put(b);
						lits--;
						if (lits == 0) begin
							if (ended) phase = P_DONE;
							else if (cmd < 8'hE0) r.st = start_copy();
							else phase = P_CMD;
						end
					end
					P_COPY: r.st = ST_BUSY_COPY;
					P_DONE: r.st = ST_AFTER_END;
					default: r.st = ST_SIZE_ERR;
				endcase
			end
			r.pend = (phase == P_COPY && mleft != 0);
			r.fin = (phase == P_DONE);
			expq.push_back(r);
		endfunction

		task report(string what, int got, int want);
			nerrors++;
			$display("[%0t] mismatch on result %0d: %s got %0h expected %0h",
				$time, nchecked, what, got, want);
		endtask

		task check(logic [15:0] d);
			lz_result_t e;
			if (expq.size() == 0) begin
				report("unexpected result", int'(d), 0);
				return;
			end
			e = expq.pop_front();
			if (d[0] !== e.v) report("byte_valid", int'(d[0]), int'(e.v));
			if (d[8:1] !== e.ob) report("out_byte", int'(d[8:1]), int'(e.ob));
			if (d[9] !== e.pend) report("copy_pending", int'(d[9]), int'(e.pend));
			if (d[10] !== e.fin) report("finished", int'(d[10]), int'(e.fin));
			if (d[13:11] !== e.st) report("status", int'(d[13:11]), int'(e.st));
			nchecked++;
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;
	logic        cfg_wen = 0;
	logic [23:0] cfg_wdata = '0;

	lz_scoreboard sb;
	int sent = 0, streams = 0, cycles = 0;
	int budget;

	refpack_lz_decompressor dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	// Send one request; idle gaps come in bursts with calm stretches between
	task send(logic [1:0] op, logic [7:0] b);
		int gap;
		gap = ((sent / 64) % 3 == 1) ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {6'd0, b, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note(op, b);
		sent++;
	endtask

	task send_byte(logic [7:0] b);
		send(OP_BYTE, b);
	endtask

	task send_lits(int n);
		repeat (n) send_byte(8'($urandom));
	endtask

	// Drain the pending copy, now and then poking a byte into it
	task drain_copy();
		while (sb.phase == P_COPY && sb.mleft != 0) begin
			if ($urandom_range(0, 15) == 0) send_byte(8'($urandom));
			send(OP_DRAIN, 8'($urandom));
		end
	endtask

	// Pick a back-reference distance, occasionally one reaching past the start
	function int pick_dist(int avail, int maxd);
		int hi;
		if ($urandom_range(0, 19) == 0)
			return ($urandom_range(0, 1)) ? avail + 1 : $urandom_range(1, maxd);
		hi = (avail < maxd) ? avail : maxd;
		if (hi < 1) return 1;
		return ($urandom_range(0, 1)) ? $urandom_range(1, hi) : $urandom_range(1, (hi < 16) ? hi : 16);
	endfunction

	task idle_wait();
		while (sb.expq.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task write_len(logic [23:0] v);
		idle_wait();
		cfg_wen <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 0;
		sb.exp_len = v;
	endtask

	// One stream: header, random commands, mostly an end command
	task gen_stream();
		logic [7:0] flag, c, b1;
		logic [23:0] size;
		int lit, d, len, ncmd, kind;
		bit good;
		good = ($urandom_range(0, 7) != 0);
		streams++;
		send(OP_RESTART, 8'($urandom));
		flag = 8'($urandom);
		send_byte(flag);
		if (flag[0]) send_lits(3);
		send_byte(8'($urandom));
		size = good ? sb.exp_len : sb.exp_len ^ (24'd1 << $urandom_range(0, 23));
		send_byte(size[23:16]);
		send_byte(size[15:8]);
		send_byte(size[7:0]);
		if (!good) begin
			send_lits($urandom_range(1, 3));
			return;
		end
		ncmd = $urandom_range(3, 12);
		repeat (ncmd) begin
			if (sent >= budget) break;
			kind = $urandom_range(0, 9);
			lit = $urandom_range(0, 3);
			if (kind <= 2) begin
				c = 8'hE0 + 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 27)
					: $urandom_range(0, 3));
				send_byte(c);
				send_lits(int'(c[4:0]) * 4 + 4);
			end else if (kind <= 5) begin
				d = pick_dist(int'(sb.written) + lit, 1024) - 1;
				len = $urandom_range(0, 7);
				send_byte({1'b0, d[9:8], len[2:0], lit[1:0]});
				send_byte(d[7:0]);
				send_lits(lit);
				drain_copy();
			end else if (kind <= 7) begin
				d = pick_dist(int'(sb.written) + lit, 16384) - 1;
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
				b1 = {lit[1:0], d[13:8]};
				send_byte({2'b10, len[5:0]});
				send_byte(b1);
				send_byte(d[7:0]);
				send_lits(lit);
				drain_copy();
			end else if (kind == 8) begin
				d = pick_dist(int'(sb.written) + lit, 131072) - 1;
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 12);
				send_byte({3'b110, d[16], len[9:8], lit[1:0]});
				send_byte(d[15:8]);
				send_byte(d[7:0]);
				send_byte(len[7:0]);
				send_lits(lit);
				drain_copy();
			end else begin
				send(($urandom_range(0, 1)) ? OP_DRAIN : OP_NOP, 8'($urandom));
			end
		end
		if ($urandom_range(0, 3) != 0) begin
			lit = $urandom_range(0, 3);
			send_byte({6'b111111, lit[1:0]});
			send_lits(lit);
			if ($urandom_range(0, 1)) send_byte(8'($urandom));
		end
	endtask

	// Receiver with random stalls and one long hold-off
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (sb.nchecked == 250) begin
				m_tready <= 0;
				repeat (300) @(posedge clk);
			end else begin
				gap = ((sb.nchecked / 80) % 3 == 2) ? 0 : $urandom_range(0, 15);
				if (gap > 0) begin
					m_tready <= 0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			sb.check(m_tdata);
		end
	end

	initial begin
		logic [23:0] lens [4];
		sb = new();
		sb.init();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: idle opcodes, plain header, literals, copy, bad reference, end, restart, size mismatch
		send(OP_NOP, 8'hFF);
		send(OP_DRAIN, 8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
		send_byte(8'hE0);
		send_byte(8'h00); send_byte(8'hFF); send_byte(8'hAA); send_byte(8'h55);
		send_byte(8'h00); send_byte(8'h03);       // short copy, distance 4, length 3
		send_byte(8'h5A);                         // byte during copy
		repeat (4) send(OP_DRAIN, 8'h00);         // last one finds nothing pending
		send_byte(8'h00); send_byte(8'hFF);       // distance 256 before start
		send_byte(8'hFF); send_lits(3);           // end command with three literals
		send_byte(8'h11);                         // byte after end
		send(OP_RESTART, 8'h00);
		send_byte(8'h01); send_lits(3); send_byte(8'h00);
		send_byte(8'h12); send_byte(8'h34); send_byte(8'h56);  // size mismatch
		send_byte(8'h77);

		// Random streams under several length settings
		lens = '{24'hFFFFFF, 24'h000000, 24'($urandom), 24'($urandom)};
		foreach (lens[i]) begin
			s_tvalid <= 0;
			write_len(lens[i]);
			budget = 30 + (i + 1) * 270;
			while (sent < budget) gen_stream();
		end
		s_tvalid <= 0;

		idle_wait();
		repeat (20) @(posedge clk);
		$display("covered %0d requests in %0d streams, %0d results checked, %0d left over",
			sent, streams, sb.nchecked, sb.expq.size());
		if (sb.nerrors == 0 && sb.expq.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

[filelist.f]
rtl/core/rlz_pkg.sv
rtl/core/rlz_ram.sv
rtl/core/rlz_front.sv
rtl/core/rlz_fifo.sv
rtl/core/rlz_back.sv
rtl/core/refpack_lz_decompressor.sv
verif/tb_refpack_lz_decompressor.sv
